>>> hdl/mssd_pkg.sv
package mssd_pkg;

  // Operation codes of the input channel.
  localparam logic [1:0] OP_FIRST_NOTE  = 2'd0;
  localparam logic [1:0] OP_SECOND_NOTE = 2'd1;
  localparam logic [1:0] OP_TICK        = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TWO_NOTE_MODE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NOTE_TIMEOUT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_COUNT    = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Field widths.
  localparam int unsigned VEL_W  = 7;
  localparam int unsigned STEP_W = 14;
  localparam int unsigned TICK_W = 16;

  // Register reset values and lower limits.
  localparam logic [TICK_W-1:0] NOTE_TIMEOUT_RST = 16'd1000;
  localparam logic [TICK_W-1:0] NOTE_TIMEOUT_MIN = 16'd100;
  localparam logic [TICK_W-1:0] DEBOUNCE_RST     = 16'd100;
  localparam logic [TICK_W-1:0] DEBOUNCE_MIN     = 16'd1;
  localparam logic [TICK_W-1:0] PEND_TICKS_MIN   = 16'd10;
  localparam logic [TICK_W-1:0] TICK_SAT         = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       operation;
    logic [VEL_W-1:0] velocity;
    logic             sequence_running;
  } in_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_index;
    logic              start_sequence;
  } out_item_t;

  // Working state of the step selector.
  typedef struct packed {
    logic              waiting_second;
    logic [VEL_W-1:0]  first_velocity;
    logic [TICK_W-1:0] note_countdown;
    logic              pending_valid;
    logic [STEP_W-1:0] pending_step;
    logic [TICK_W-1:0] pend_countdown;
    logic              last_change_valid;
    logic [TICK_W-1:0] since_change;
  } sel_state_t;

  // Outcome of offering one step to the debounce stage.
  typedef struct packed {
    sel_state_t st;
    logic       fire;
  } queue_res_t;

endpackage

>>> hdl/midi_step_select_debouncer.sv
// Step selector with debounce. Each input transfer carries a first note
// velocity, a second note velocity or a one millisecond tick; each may yield
// at most one step selection on the result channel. Every item is handled by the
// combinational selector logic in front of a two-entry result queue, so a new
// item is taken every cycle; the input stalls only when both result entries are
// full. Configuration writes through cfg_we take effect at once and are
// meant for times when no item is in flight.
module midi_step_select_debouncer
  import mssd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic              enable_r, enable_nxt;
  logic              two_note_r, two_note_nxt;
  logic [TICK_W-1:0] note_timeout_r, note_timeout_nxt;
  logic [TICK_W-1:0] debounce_r, debounce_nxt;
  logic [STEP_W-1:0] step_count_r, step_count_nxt;

  sel_state_t st_r, st_nxt;

  // Result queue: head register and one skid entry.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_r, skid_nxt;

  logic      accept;
  logic      push;
  logic      pop;
  out_item_t res;

  // Offer step s to the debounce stage: issue it now, hold it as pending, or drop it when disabled or out of range.
  function automatic queue_res_t queue_step(input sel_state_t st,
                                            input logic [STEP_W-1:0] s,
                                            input logic en,
                                            input logic [STEP_W-1:0] count,
                                            input logic [TICK_W-1:0] deb);
    queue_res_t        r;
    logic [TICK_W-1:0] rem;
    r.st   = st;
    r.fire = 1'b0;
    rem    = deb - st.since_change;
    if (en && (s < count)) begin
      r.st.pending_step  = s;
      r.st.pending_valid = 1'b1;
      if (st.last_change_valid && (st.since_change < deb)) begin
        if (st.pend_countdown == '0) begin
          r.st.pend_countdown = (rem < PEND_TICKS_MIN) ? PEND_TICKS_MIN : rem;
        end
      end else begin
        r.st.pending_valid     = 1'b0;
        r.st.pending_step      = '0;
        r.st.last_change_valid = 1'b1;
        r.st.since_change      = '0;
        r.fire                 = 1'b1;
      end
    end
    return r;
  endfunction

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Selector: one item, then any configuration write on top.
  always_comb begin
    sel_state_t        s;
    queue_res_t        q;
    logic              fire;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] combined;
    logic [VEL_W-1:0]  f;
    s        = st_r;
    fire     = 1'b0;
    step     = '0;
    combined = {st_r.first_velocity, in_data.velocity};
    f        = st_r.first_velocity;
    q        = '0;

    if (accept) begin
      unique case (in_data.operation)
        OP_FIRST_NOTE: begin
          if (enable_r) begin
            if (two_note_r) begin
              s.first_velocity = in_data.velocity;
              s.waiting_second = 1'b1;
              s.note_countdown = note_timeout_r;
            end else if (in_data.velocity != '0) begin
              step = STEP_W'(in_data.velocity) - STEP_W'(1);
              q    = queue_step(s, step, enable_r, step_count_r, debounce_r);
              s    = q.st;
              fire = q.fire;
            end
          end
        end
        OP_SECOND_NOTE: begin
          if (enable_r && two_note_r && st_r.waiting_second) begin
            s.waiting_second = 1'b0;
            s.first_velocity = '0;
            s.note_countdown = '0;
            if (combined != '0) begin
              step = combined - STEP_W'(1);
              q    = queue_step(s, step, enable_r, step_count_r, debounce_r);
              s    = q.st;
              fire = q.fire;
            end
          end
        end
        OP_TICK: begin
          // Time since the last issued change, saturating.
          if (s.last_change_valid && (s.since_change != TICK_SAT)) begin
            s.since_change = s.since_change + TICK_W'(1);
          end
          // Debounce countdown first.
          if (s.pend_countdown != '0) begin
            s.pend_countdown = s.pend_countdown - TICK_W'(1);
            if ((s.pend_countdown == '0) && enable_r && s.pending_valid) begin
              step            = s.pending_step;
              s.pending_valid = 1'b0;
              s.pending_step  = '0;
              if (step < step_count_r) begin
                s.last_change_valid = 1'b1;
                s.since_change      = '0;
                fire                = 1'b1;
              end
            end
          end
          // Then the note timeout. After an issue in this tick the step
          // lands as pending or is dropped, so the earlier result stands.
          if (s.waiting_second) begin
            if (s.note_countdown > TICK_W'(1)) begin
              s.note_countdown = s.note_countdown - TICK_W'(1);
            end else begin
              s.waiting_second = 1'b0;
              s.first_velocity = '0;
              s.note_countdown = '0;
              if (f != '0) begin
                q = queue_step(s, STEP_W'(f) - STEP_W'(1), enable_r,
                               step_count_r, debounce_r);
                s = q.st;
                if (!fire && q.fire) begin
                  step = STEP_W'(f) - STEP_W'(1);
                  fire = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          // Unused operation code: no effect.
        end
      endcase
    end

    enable_nxt       = enable_r;
    two_note_nxt     = two_note_r;
    note_timeout_nxt = note_timeout_r;
    debounce_nxt     = debounce_r;
    step_count_nxt   = step_count_r;

    // Configuration writes.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: begin
          enable_nxt = cfg_wdata[0];
          if (!cfg_wdata[0]) begin
            s.waiting_second = 1'b0;
            s.first_velocity = '0;
            s.note_countdown = '0;
            s.pending_valid  = 1'b0;
            s.pending_step   = '0;
            s.pend_countdown = '0;
          end
        end
        CFG_TWO_NOTE_MODE: begin
          two_note_nxt = cfg_wdata[0];
          if (cfg_wdata[0] != two_note_r) begin
            s.waiting_second = 1'b0;
            s.first_velocity = '0;
            s.note_countdown = '0;
          end
        end
        CFG_NOTE_TIMEOUT: begin
          note_timeout_nxt = (cfg_wdata < NOTE_TIMEOUT_MIN) ? NOTE_TIMEOUT_MIN : cfg_wdata;
        end
        CFG_DEBOUNCE: begin
          debounce_nxt = (cfg_wdata < DEBOUNCE_MIN) ? DEBOUNCE_MIN : cfg_wdata;
        end
        CFG_STEP_COUNT: begin
          step_count_nxt = cfg_wdata[STEP_W-1:0];
        end
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end

    st_nxt             = s;
    push               = fire;
    res.step_index     = step;
    res.start_sequence = !in_data.sequence_running;
  end

  // Result queue next state.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_nxt       = res;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      two_note_r     <= 1'b0;
      note_timeout_r <= NOTE_TIMEOUT_RST;
      debounce_r     <= DEBOUNCE_RST;
      step_count_r   <= '0;
      st_r           <= '0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      enable_r       <= enable_nxt;
      two_note_r     <= two_note_nxt;
      note_timeout_r <= note_timeout_nxt;
      debounce_r     <= debounce_nxt;
      step_count_r   <= step_count_nxt;
      st_r           <= st_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> hdl/mssd_checker.sv
module mssd_checker
  import mssd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result only appears after an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an input transfer");

  // The input stalls only while a result is waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result queue");

  // An issued step is always below some step count, so never all ones.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.step_index != {STEP_W{1'b1}}))
    else $error("step index out of range");

  // A waiting result holds until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting result dropped or changed");

endmodule

bind midi_step_select_debouncer mssd_checker u_mssd_checker (.*);

>>> tb/sv/tb_midi_step_select_debouncer.sv
`timescale 1ns / 100ps

module tb_midi_step_select_debouncer;
  import mssd_pkg::*;

  // Codes the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Mirror of the configuration and the selector state.
  logic              cfg_en;
  logic              cfg_two;
  logic [TICK_W-1:0] cfg_note_to;
  logic [TICK_W-1:0] cfg_deb;
  logic [STEP_W-1:0] cfg_steps;
  sel_state_t        sel_st;
  out_item_t         expected_steps[$];

  int send_idle_pct = 22;
  int recv_idle_pct = 68;
  int hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_accepted = 0;
  int steps_checked = 0;
  int mismatch_count = 0;
  int phase_count = 0;

  midi_step_select_debouncer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d steps outstanding.", cycle_count,
               expected_steps.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Step selector predictor.
  function automatic void reset_model();
    cfg_en = 1'b0;
    cfg_two = 1'b0;
    cfg_note_to = NOTE_TIMEOUT_RST;
    cfg_deb = DEBOUNCE_RST;
    cfg_steps = '0;
    sel_st = '0;
    expected_steps.delete();
  endfunction

  function automatic void clear_pair();
    sel_st.waiting_second = 1'b0;
    sel_st.first_velocity = '0;
    sel_st.note_countdown = '0;
  endfunction

  function automatic void apply_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_ENABLE: begin
        cfg_en = d[0];
        if (!cfg_en) begin
          clear_pair();
          sel_st.pending_valid = 1'b0;
          sel_st.pending_step = '0;
          sel_st.pend_countdown = '0;
        end
      end
      CFG_TWO_NOTE_MODE: begin
        if (d[0] != cfg_two) begin
          cfg_two = d[0];
          clear_pair();
        end
      end
      CFG_NOTE_TIMEOUT: cfg_note_to = (d < NOTE_TIMEOUT_MIN) ? NOTE_TIMEOUT_MIN : d;
      CFG_DEBOUNCE:     cfg_deb = (d < DEBOUNCE_MIN) ? DEBOUNCE_MIN : d;
      CFG_STEP_COUNT:   cfg_steps = d[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // Issue the pending step if it is still in range.
  function automatic bit release_pending(logic run, output out_item_t r);
    logic [STEP_W-1:0] s;
    r = '0;
    if (!cfg_en || !sel_st.pending_valid) return 1'b0;
    s = sel_st.pending_step;
    sel_st.pending_valid = 1'b0;
    sel_st.pending_step = '0;
    if (s >= cfg_steps) return 1'b0;
    r.step_index = s;
    r.start_sequence = ~run;
    sel_st.last_change_valid = 1'b1;
    sel_st.since_change = '0;
    return 1'b1;
  endfunction

  // A requested step goes out at once, waits out the debounce interval, or is dropped when disabled or out of range.
  function automatic bit offer_step(logic [STEP_W-1:0] s, logic run, output out_item_t r);
    logic [TICK_W-1:0] rem;
    r = '0;
    if (!cfg_en || s >= cfg_steps) return 1'b0;
    sel_st.pending_step = s;
    sel_st.pending_valid = 1'b1;
    if (sel_st.last_change_valid && sel_st.since_change < cfg_deb) begin
      if (sel_st.pend_countdown == '0) begin
        rem = cfg_deb - sel_st.since_change;
        sel_st.pend_countdown = (rem < PEND_TICKS_MIN) ? PEND_TICKS_MIN : rem;
      end
      return 1'b0;
    end
    return release_pending(run, r);
  endfunction

  function automatic bit predict_item(in_item_t it, output out_item_t r);
    logic [STEP_W-1:0] pair;
    logic [VEL_W-1:0]  f;
    out_item_t         scratch;
    bit                hit;
    r = '0;
    hit = 1'b0;
    case (it.operation)
      OP_FIRST_NOTE: begin
        if (!cfg_en) return 1'b0;
        if (cfg_two) begin
          sel_st.first_velocity = it.velocity;
          sel_st.waiting_second = 1'b1;
          sel_st.note_countdown = cfg_note_to;
          return 1'b0;
        end
        if (it.velocity == '0) return 1'b0;
        return offer_step({7'd0, it.velocity} - 14'd1, it.sequence_running, r);
      end
      OP_SECOND_NOTE: begin
        if (!cfg_en || !cfg_two || !sel_st.waiting_second) return 1'b0;
        pair = {sel_st.first_velocity, it.velocity};
        clear_pair();
        if (pair == '0) return 1'b0;
        return offer_step(pair - 14'd1, it.sequence_running, r);
      end
      OP_TICK: begin
        if (sel_st.last_change_valid && sel_st.since_change < TICK_SAT)
          sel_st.since_change++;
        // The debounce countdown is served before the note timeout.
        if (sel_st.pend_countdown != '0) begin
          sel_st.pend_countdown--;
          if (sel_st.pend_countdown == '0) hit = release_pending(it.sequence_running, r);
        end
        if (sel_st.waiting_second) begin
          if (sel_st.note_countdown > 16'd1) begin
            sel_st.note_countdown--;
          end else begin
            f = sel_st.first_velocity;
            clear_pair();
            if (f != '0) begin
              if (!hit) hit = offer_step({7'd0, f} - 14'd1, it.sequence_running, r);
              else void'(offer_step({7'd0, f} - 14'd1, it.sequence_running, scratch));
            end
          end
        end
        return hit;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Track register writes, predict each input transfer and check each result.
  always @(posedge clk) begin : monitor
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) apply_config(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        items_accepted++;
        if (predict_item(in_data, got)) expected_steps.push_back(got);
      end
      if (out_valid && out_ready) begin
        steps_checked++;
        if (expected_steps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result: step %0d start %0b", $time,
                     out_data.step_index, out_data.start_sequence);
        end else begin
          want = expected_steps.pop_front();
          if (out_data.step_index !== want.step_index ||
              out_data.start_sequence !== want.start_sequence) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] mismatch: expected step %0d start %0b, got step %0d start %0b",
                       $time, want.step_index, want.start_sequence,
                       out_data.step_index, out_data.start_sequence);
          end
        end
      end
    end
  end

  // Result side: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item after a random gap and wait for its transfer.
  task automatic send_item(logic [1:0] op, logic [VEL_W-1:0] vel, logic run);
    in_item_t it;
    it.operation = op;
    it.velocity = vel;
    it.sequence_running = run;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 7'($urandom_range(127)), 1'($urandom_range(1)));
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_tick();
  endtask

  // Register writes happen with the input channel idle.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Let every expected step arrive and the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VEL_W-1:0] pick_velocity();
    int p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 16) return 7'd127;
    if (p < 20) return 7'd1;
    return 7'($urandom_range(127));
  endfunction

  // First velocities near the step count boundary make two-note steps land in range.
  function automatic logic [VEL_W-1:0] pick_first();
    int hi;
    hi = (cfg_steps >> 7) + 1;
    if (hi > 127) hi = 127;
    if ($urandom_range(1)) return 7'($urandom_range(hi));
    return pick_velocity();
  endfunction

  task automatic test_reset_defaults();
    // Disabled after reset: notes are dropped and ticks have no effect.
    send_item(OP_FIRST_NOTE, 7'd9, 1'b0);
    send_tick();
    // Enabled with no valid steps yet.
    write_reg(CFG_ENABLE, 16'hFFFF);
    send_item(OP_FIRST_NOTE, 7'd9, 1'b1);
    wait_drained();
  endtask

  task automatic test_single_note();
    write_reg(CFG_STEP_COUNT, 16'hFFFF);
    write_reg(CFG_DEBOUNCE, 16'h0000);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_item(OP_FIRST_NOTE, 7'd1, 1'b0);
    send_tick();
    send_item(OP_FIRST_NOTE, 7'd127, 1'b1);
    // Too soon after the last change, so this one waits.
    send_item(OP_FIRST_NOTE, 7'd64, 1'b0);
    send_item(OP_FIRST_NOTE, 7'd0, 1'b1);
    send_item(OP_UNUSED, 7'h55, 1'b1);
    send_item(OP_SECOND_NOTE, 7'h2A, 1'b0);
    send_ticks(10);
    wait_drained();
  endtask

  task automatic test_two_note();
    write_reg(CFG_TWO_NOTE_MODE, 16'h0001);
    write_reg(CFG_NOTE_TIMEOUT, 16'h0000);
    send_tick();
    send_item(OP_FIRST_NOTE, 7'd127, 1'b0);
    send_item(OP_SECOND_NOTE, 7'd127, 1'b1);
    send_tick();
    send_item(OP_FIRST_NOTE, 7'd0, 1'b1);
    send_item(OP_SECOND_NOTE, 7'd0, 1'b0);
    send_item(OP_FIRST_NOTE, 7'd0, 1'b0);
    send_item(OP_SECOND_NOTE, 7'd1, 1'b1);
    send_tick();
    wait_drained();
  endtask

  // The debounce countdown and the note timeout end on the same tick.
  task automatic test_timeout_collision();
    write_reg(CFG_DEBOUNCE, 16'd105);
    write_reg(CFG_NOTE_TIMEOUT, 16'd99);
    send_ticks(110);
    send_item(OP_FIRST_NOTE, 7'd2, 1'b0);
    send_item(OP_SECOND_NOTE, 7'd5, 1'b0);
    send_item(OP_FIRST_NOTE, 7'd3, 1'b1);
    send_item(OP_SECOND_NOTE, 7'd6, 1'b1);
    send_ticks(5);
    send_item(OP_FIRST_NOTE, 7'd4, 1'b0);
    send_ticks(100);
    wait_drained();
  endtask

  // Stall the result side long enough that the block stops taking input.
  task automatic test_backpressure();
    write_reg(CFG_TWO_NOTE_MODE, 16'h0000);
    write_reg(CFG_DEBOUNCE, 16'h0001);
    hold_req = HOLD_CYCLES;
    repeat (40) begin
      send_item(OP_FIRST_NOTE, 7'($urandom_range(1, 127)), 1'($urandom_range(1)));
      send_tick();
    end
    wait_drained();
  endtask

  // Pick the registers of one phase; kinds 1 and 2 use the extremes.
  task automatic setup_phase(int kind);
    logic [TICK_W-1:0] to;
    logic [TICK_W-1:0] db;
    logic [TICK_W-1:0] sc;
    logic              en;
    en = ($urandom_range(9) != 0);
    if (kind == 1) begin
      to = 16'hFFFF;
      db = 16'hFFFF;
      sc = 16'hFFFF;
      en = 1'b1;
    end else if (kind == 2) begin
      to = 16'd99;
      db = 16'd0;
      sc = 16'h3FFF;
      en = 1'b1;
    end else begin
      to = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                    : 16'($urandom_range(100, 130));
      db = ($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF))
                                    : 16'($urandom_range(40));
      case ($urandom_range(7))
        0: sc = 16'd0;
        1: sc = 16'd1;
        2: sc = 16'd127;
        3: sc = 16'd128;
        4: sc = 16'd129;
        5: sc = 16'd300;
        6: sc = 16'hFFFF;
        default: sc = 16'($urandom_range(16'hFFFF));
      endcase
    end
    write_reg(CFG_TWO_NOTE_MODE, {15'($urandom_range(16'h7FFF)), 1'($urandom_range(1))});
    write_reg(CFG_NOTE_TIMEOUT, to);
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_STEP_COUNT, sc);
    write_reg(CFG_ENABLE, {15'($urandom_range(16'h7FFF)), en});
  endtask

  // Mostly well-formed note sequences and tick runs, with some noise.
  task automatic random_phase(int n_items);
    int remaining;
    int pick;
    int k;
    remaining = n_items;
    while (remaining > 0) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(($urandom_range(1) != 0) ? OP_UNUSED : OP_SECOND_NOTE,
                  7'($urandom_range(127)), 1'($urandom_range(1)));
        remaining--;
      end else if (pick < 45) begin
        k = $urandom_range(1, 15);
        send_ticks(k);
        remaining -= k;
      end else if (pick < 48 && cfg_two && cfg_note_to <= 16'd140) begin
        // Let the first note time out.
        send_item(OP_FIRST_NOTE, pick_first(), 1'($urandom_range(1)));
        k = int'(cfg_note_to) + $urandom_range(2);
        send_ticks(k);
        remaining -= k + 1;
      end else if (cfg_two) begin
        send_item(OP_FIRST_NOTE, pick_first(), 1'($urandom_range(1)));
        k = $urandom_range(3);
        send_ticks(k);
        send_item(OP_SECOND_NOTE, pick_velocity(), 1'($urandom_range(1)));
        remaining -= k + 2;
      end else begin
        send_item(OP_FIRST_NOTE, pick_velocity(), 1'($urandom_range(1)));
        remaining--;
      end
    end
  endtask

  task automatic test_random_traffic();
    int round;
    int ph;
    for (round = 0; round < 3; round++) begin
      case (round)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (ph = 0; ph < 6; ph++) begin
        wait_drained();
        setup_phase((ph < 2) ? ph + 1 : 0);
        random_phase(90);
        phase_count++;
      end
    end
    wait_drained();
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_single_note();
    test_two_note();
    test_timeout_collision();
    test_backpressure();
    test_random_traffic();
    $display("Ran %0d input transfers: directed cases, a long result stall and %0d random phases.",
             items_accepted, phase_count);
    $display("Checked %0d step selections with %0d mismatches.", steps_checked, mismatch_count);
    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
